// File: rtl/rfes_pkg.sv
// shared types, constants and codes of the reaction free-energy summer
package rfes_pkg;

  localparam int NUM_MOLECULES_DEF = 1024;

  localparam int IDX_W    = 10;
  localparam int ENERGY_W = 32;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = ENERGY_W + COEF_W;
  localparam int SUM_W    = 54;
  localparam int STATUS_W = 3;
  localparam int MEM_W    = ENERGY_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam int RES_FIFO_DEPTH = 4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TERM = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COMPUTE_FROM_FORMATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_IN_OVERRIDES      = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_COMPUTED  = 3'd0,
    ST_READ_IN   = 3'd1,
    ST_MISSING   = 3'd2,
    ST_NOT_COMP  = 3'd3,
    ST_SKIPPED   = 3'd4
  } status_t;

  typedef struct packed {
    logic valid;
    logic term_valid;
    logic in_range;
    logic last;
    logic given;
  } stage1_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic miss;
    logic last;
    logic given;
  } stage2_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] energy;
    status_t                 status;
  } result_t;

endpackage

// File: rtl/reaction_free_energy_sum.sv
// top level of the reaction free-energy summer
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------
//   item     | item_valid / item_stall   | command .. last_term, one beat each
//   result   | result_valid / result_stall | reaction_energy, result_status
//   config   | cfg_we                    | cfg_index, cfg_data
//
// one item beat per cycle while item_stall is low; results pass s1, s2, the fifo
// the energy table lives in one ram; a term reads it, multiplies, then accumulates
// after reset a clearing pass zeroes every table entry and holds item_stall high
// up to four results wait in a queue; item_stall rises while four are pending
module reaction_free_energy_sum import rfes_pkg::*; #(
  parameter int NUM_MOLECULES = NUM_MOLECULES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       command,
  input  logic [IDX_W-1:0]           molecule_index,
  input  logic signed [ENERGY_W-1:0] energy,
  input  logic                       energy_known,
  input  logic signed [COEF_W-1:0]   coefficient,
  input  logic                       given_status,
  input  logic                       term_valid,
  input  logic                       last_term,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SUM_W-1:0]    reaction_energy,
  output logic [STATUS_W-1:0]        result_status,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W  = $clog2(NUM_MOLECULES);
  localparam int EXT_W   = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int PEND_W  = $clog2(RES_FIFO_DEPTH + 1);

  logic                       compute_from_formation;
  logic                       read_in_overrides;

  logic                       clearing;
  logic [ADDR_W-1:0]          clr_addr;

  logic [PEND_W-1:0]          pend;
  logic                       item_fire;
  logic                       result_fire;
  logic                       last_fire;

  logic [EXT_W-1:0]           idx_ext;
  logic [ADDR_W-1:0]          idx_addr;
  logic                       in_range;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [MEM_W-1:0]           ram_wdata;
  logic [MEM_W-1:0]           ram_rdata;

  stage1_t                    s1;
  logic signed [COEF_W-1:0]   s1_coef;
  stage2_t                    s2;
  logic signed [PROD_W-1:0]   s2_prod;

  logic                       push;
  result_t                    push_data;
  result_t                    head;

  assign idx_ext  = EXT_W'(molecule_index);
  assign idx_addr = idx_ext[ADDR_W-1:0];
  assign in_range = (idx_ext < EXT_W'(NUM_MOLECULES));

  assign item_stall  = clearing | (pend >= PEND_W'(RES_FIFO_DEPTH));
  assign item_fire   = item_valid & ~item_stall;
  assign result_fire = result_valid & ~result_stall;
  assign last_fire   = item_fire & (command == CMD_TERM) & last_term;

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = item_fire & (command == CMD_LOAD) & in_range;
      ram_waddr = idx_addr;
      ram_wdata = {energy_known, energy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compute_from_formation <= 1'b1;
      read_in_overrides      <= 1'b0;
      clearing               <= 1'b1;
      clr_addr               <= '0;
      pend                   <= '0;
      s1                     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COMPUTE_FROM_FORMATION: compute_from_formation <= cfg_data[0];
          REG_READ_IN_OVERRIDES:      read_in_overrides      <= cfg_data[0];
          default: ;
        endcase
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(NUM_MOLECULES - 1)) begin
          clearing <= 1'b0;
        end
      end
      pend <= pend + PEND_W'(last_fire) - PEND_W'(result_fire);
      s1.valid      <= item_fire & (command == CMD_TERM);
      s1.term_valid <= term_valid;
      s1.in_range   <= in_range;
      s1.last       <= last_term;
      s1.given      <= given_status;
    end
    s1_coef <= coefficient;
  end

  rfes_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_MOLECULES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_addr),
    .rdata (ram_rdata)
  );

  rfes_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .s1      (s1),
    .s1_coef (s1_coef),
    .rdata   (ram_rdata),
    .s2      (s2),
    .s2_prod (s2_prod)
  );

  rfes_acc u_acc (
    .clk                    (clk),
    .rst                    (rst),
    .s2                     (s2),
    .s2_prod                (s2_prod),
    .compute_from_formation (compute_from_formation),
    .read_in_overrides      (read_in_overrides),
    .push                   (push),
    .res                    (push_data)
  );

  rfes_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (result_fire),
    .not_empty (result_valid),
    .head      (head)
  );

  assign reaction_energy = head.energy;
  assign result_status   = head.status;

endmodule

// File: rtl/rfes_ram.sv
// generic single-write, single-read ram with registered read data
module rfes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rfes_mul.sv
// term multiply stage: coefficient times table energy, hit and miss flags
module rfes_mul import rfes_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  stage1_t                  s1,
  input  logic signed [COEF_W-1:0] s1_coef,
  input  logic [MEM_W-1:0]         rdata,
  output stage2_t                  s2,
  output logic signed [PROD_W-1:0] s2_prod
);

  logic                       known;
  logic signed [ENERGY_W-1:0] tab_energy;
  logic                       hit;

  assign known      = rdata[MEM_W-1];
  assign tab_energy = $signed(rdata[ENERGY_W-1:0]);
  assign hit        = s1.term_valid & s1.in_range & known;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2.valid <= s1.valid;
      s2.hit   <= hit;
      s2.miss  <= s1.term_valid & ~hit;
      s2.last  <= s1.last;
      s2.given <= s1.given;
    end
    s2_prod <= s1_coef * tab_energy;
  end

endmodule

// File: rtl/rfes_acc.sv
// saturating accumulator and per-reaction status decision
module rfes_acc import rfes_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  stage2_t                  s2,
  input  logic signed [PROD_W-1:0] s2_prod,
  input  logic                     compute_from_formation,
  input  logic                     read_in_overrides,
  output logic                     push,
  output result_t                  res
);

  logic signed [SUM_W-1:0] running_sum;
  logic                    term_missing;
  logic                    failed_sticky;

  logic signed [SUM_W:0]   addend;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    missing_next;
  logic                    fail_now;

  assign addend   = s2.hit ? (SUM_W+1)'(s2_prod) : '0;
  assign sum_wide = {running_sum[SUM_W-1], running_sum} + addend;

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign missing_next = term_missing | s2.miss;

  always_comb begin
    res.energy = '0;
    fail_now   = 1'b0;
    if (failed_sticky) begin
      res.status = ST_SKIPPED;
    end else if (!compute_from_formation) begin
      if (s2.given) begin
        res.status = ST_READ_IN;
      end else begin
        res.status = ST_MISSING;
        fail_now   = 1'b1;
      end
    end else if (read_in_overrides && s2.given) begin
      res.status = ST_READ_IN;
    end else if (missing_next) begin
      res.status = ST_NOT_COMP;
      fail_now   = 1'b1;
    end else begin
      res.status = ST_COMPUTED;
      res.energy = sum_sat;
    end
  end

  assign push = s2.valid & s2.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      term_missing  <= 1'b0;
      failed_sticky <= 1'b0;
    end else if (s2.valid) begin
      if (s2.last) begin
        running_sum   <= '0;
        term_missing  <= 1'b0;
        failed_sticky <= failed_sticky | fail_now;
      end else begin
        running_sum  <= sum_sat;
        term_missing <= missing_next;
      end
    end
  end

endmodule

// File: rtl/rfes_fifo.sv
// small result queue between the accumulator and the output channel
module rfes_fifo import rfes_pkg::*; #(
  parameter int DEPTH = RES_FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
